### sv/hvp_pkg.sv
// Shared types, register indexes and mode codes for the HV precharge controller.
package hvp_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CTRL_TEMP_LIMIT  = 3'd0,
		CFG_MOTOR_TEMP_LIMIT = 3'd1,
		CFG_MIN_PACK_VOLTAGE = 3'd2,
		CFG_PRECHARGE_TOL    = 3'd3,
		CFG_TILT_LIMIT       = 3'd4
	} cfg_idx_t;

	// reset values of the configuration registers
	localparam logic signed [11:0] RST_CTRL_TEMP_LIMIT  = 12'sd800;
	localparam logic signed [11:0] RST_MOTOR_TEMP_LIMIT = 12'sd1200;
	localparam logic [13:0]        RST_MIN_PACK_VOLTAGE = 14'd800;
	localparam logic [6:0]         RST_PRECHARGE_TOL    = 7'd10;
	localparam logic [10:0]        RST_TILT_LIMIT       = 11'd450;

	// percent scale of the voltage gap test
	localparam logic signed [22:0] GAP_SCALE = 23'sd100;

	// encoded mode as seen on the result beat
	localparam logic [1:0] HV_OFF        = 2'd0;
	localparam logic [1:0] HV_PRECHARGE  = 2'd1;
	localparam logic [1:0] HV_ON         = 2'd2;
	localparam logic [1:0] HV_FAULT      = 2'd3;

	typedef enum logic [3:0] {
		MODE_OFF        = 4'b0001,
		MODE_PRECHARGING = 4'b0010,
		MODE_ON         = 4'b0100,
		MODE_ERROR      = 4'b1000
	} mode_t;

	typedef struct packed {
		logic signed [11:0] controller_temp_limit;
		logic signed [11:0] motor_temp_limit;
		logic [13:0]        min_pack_voltage;
		logic [6:0]         precharge_tolerance_percent;
		logic [10:0]        tilt_limit;
	} cfg_t;

	typedef struct packed {
		logic               hv_switch_on;
		logic               cells_ready;
		logic [13:0]        pack_voltage;
		logic [13:0]        controller_voltage;
		logic signed [11:0] controller_temp;
		logic signed [11:0] motor_temp;
		logic signed [11:0] yaw;
		logic signed [11:0] roll;
	} in_t;

	typedef struct packed {
		logic [1:0] hv_mode;
		logic       contactor_closed;
		logic       precharge_closed;
		logic       mode_changed;
	} out_t;

	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] c;
		case (m)
			MODE_OFF:         c = HV_OFF;
			MODE_PRECHARGING: c = HV_PRECHARGE;
			MODE_ON:          c = HV_ON;
			MODE_ERROR:       c = HV_FAULT;
			default:          c = HV_OFF;
		endcase
		return c;
	endfunction

endpackage

### sv/hvp_cfg_regs.sv
// Configuration register bank of the HV precharge controller.
module hvp_cfg_regs
	import hvp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.controller_temp_limit       <= RST_CTRL_TEMP_LIMIT;
			cfg_q.motor_temp_limit            <= RST_MOTOR_TEMP_LIMIT;
			cfg_q.min_pack_voltage            <= RST_MIN_PACK_VOLTAGE;
			cfg_q.precharge_tolerance_percent <= RST_PRECHARGE_TOL;
			cfg_q.tilt_limit                  <= RST_TILT_LIMIT;
		end else if (wr_en) begin
			case (index)
				CFG_CTRL_TEMP_LIMIT:  cfg_q.controller_temp_limit       <= $signed(data[11:0]);
				CFG_MOTOR_TEMP_LIMIT: cfg_q.motor_temp_limit            <= $signed(data[11:0]);
				CFG_MIN_PACK_VOLTAGE: cfg_q.min_pack_voltage            <= data[13:0];
				CFG_PRECHARGE_TOL:    cfg_q.precharge_tolerance_percent <= data[6:0];
				CFG_TILT_LIMIT:       cfg_q.tilt_limit                  <= data[10:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/hvp_next_mode.sv
// Next-mode logic: temperature, tilt and precharge-complete checks.
module hvp_next_mode
	import hvp_pkg::*;
(
	input  mode_t mode,
	input  in_t   smp,
	input  cfg_t  cfg,
	output mode_t next
);

	logic               unsafe_temp;
	logic               tilt;
	logic               pc_done;
	logic signed [14:0] diff;
	logic signed [22:0] gap;
	logic [20:0]        allow;
	logic signed [12:0] lim_p;
	logic signed [12:0] lim_n;
	logic signed [12:0] yaw_x;
	logic signed [12:0] roll_x;

	always_comb begin
		unsafe_temp = (smp.controller_temp >= cfg.controller_temp_limit) ||
		              (smp.motor_temp >= cfg.motor_temp_limit);

		lim_p  = $signed({2'b00, cfg.tilt_limit});
		lim_n  = -lim_p;
		yaw_x  = 13'(smp.yaw);
		roll_x = 13'(smp.roll);
		tilt   = (yaw_x > lim_p) || (yaw_x < lim_n) ||
		         (roll_x > lim_p) || (roll_x < lim_n);

		// negative gap (controller above pack) always passes
		diff  = $signed({1'b0, smp.pack_voltage}) - $signed({1'b0, smp.controller_voltage});
		gap   = 23'(diff) * GAP_SCALE;
		allow = 21'(smp.pack_voltage) * 21'(cfg.precharge_tolerance_percent);
		pc_done = smp.cells_ready && (gap <= $signed({2'b00, allow})) &&
		          (smp.pack_voltage > cfg.min_pack_voltage);

		next = mode;
		if (!smp.hv_switch_on) begin
			next = MODE_OFF;
		end else begin
			case (mode)
				MODE_OFF: next = MODE_PRECHARGING;
				MODE_PRECHARGING: begin
					if (unsafe_temp)  next = MODE_ERROR;
					else if (pc_done) next = MODE_ON;
				end
				MODE_ON: begin
					if (unsafe_temp || tilt) next = MODE_ERROR;
				end
				MODE_ERROR: next = MODE_ERROR;
				default:    next = MODE_OFF;
			endcase
		end
	end

endmodule

### sv/hvp_top_dummy_placeholder.sv
// Result encoder: maps a mode transition onto the result beat fields.
module hvp_result_enc
	import hvp_pkg::*;
(
	input  mode_t old_mode,
	input  mode_t new_mode,
	output out_t  res
);

	always_comb begin
		res.hv_mode          = mode_code(new_mode);
		res.contactor_closed = (new_mode == MODE_ON);
		res.precharge_closed = (new_mode == MODE_PRECHARGING);
		res.mode_changed     = (new_mode != old_mode);
	end

endmodule

### sv/hv_precharge_controller.sv
// HV precharge controller top level: input register, mode register, result register.
// A beat in the input register moves on to the result register, and so to out_data, once
// that register is free or draining; a held result blocks it until out_ready takes the result.
// Throughput: one beat per cycle while out_ready holds; the mode update loop sets that figure.
// While a result waits, in_ready stays high only as long as the input register is empty.
// Reset (arst_n low, asynchronous): mode off, both registers empty, config registers to defaults.
module hv_precharge_controller
	import hvp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	logic  valid_s1;
	in_t   data_s1;
	mode_t mode_q;
	mode_t next_mode;
	out_t  res;
	logic  out_valid_q;
	out_t  out_q;
	logic  adv;

	hvp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	hvp_next_mode u_next (
		.mode (mode_q),
		.smp  (data_s1),
		.cfg  (cfg),
		.next (next_mode)
	);

	hvp_result_enc u_enc (
		.old_mode (mode_q),
		.new_mode (next_mode),
		.res      (res)
	);

	// a beat in the input register moves on when the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// mode advances exactly once per beat, together with the result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				mode_q      <= next_mode;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// error is only entered from precharging or on
	a_err_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && next_mode == MODE_ERROR && mode_q != MODE_ERROR) |->
		(mode_q == MODE_PRECHARGING || mode_q == MODE_ON))
		else $error("error entered from off");

	// switch low forces off on the next cycle
	a_sw_off: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !data_s1.hv_switch_on) |=> (mode_q == MODE_OFF))
		else $error("switch low did not return to off");

	// a held result always reflects the current mode
	a_res_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.hv_mode == mode_code(mode_q)))
		else $error("result mode out of step with mode register");

	// contactor and precharge relay drives follow the mode register
	a_drives: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.contactor_closed == (mode_q == MODE_ON)) &&
		                 (out_q.precharge_closed == (mode_q == MODE_PRECHARGING))))
		else $error("relay drives out of step with mode");

endmodule
